### rtl/assert_macros.svh
// assertion macros shared by the rtl files that check themselves
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/sfc_pkg.sv
// types, codes and the crc-8 step for the sync frame checker
// no dependencies
`default_nettype none

package sfc_pkg;

	localparam int unsigned FRAME_LEN = 8;
	localparam logic [3:0]  POS_LAST  = 4'(FRAME_LEN - 1);
	localparam logic [3:0]  POS_SAT   = 4'd9;
	localparam logic [7:0]  CRC_POLY  = 8'h07;
	localparam logic [7:0]  SOF_RESET = 8'hAA;

	// register index of the start marker
	localparam logic REG_SOF_MARKER = 1'b0;

	// status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_LEN = 2'd1;
	localparam logic [1:0] ST_SOF = 2'd2;
	localparam logic [1:0] ST_CRC = 2'd3;

	// event codes
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_START = 2'd1;
	localparam logic [1:0] EV_STOP  = 2'd2;
	localparam logic [1:0] EV_POLL  = 2'd3;

	// command codes
	localparam logic [7:0] CMD_START    = 8'h00;
	localparam logic [7:0] CMD_HALT     = 8'h01;
	localparam logic [7:0] CMD_HALT_REQ = 8'h02;
	localparam logic [7:0] CMD_QUERY    = 8'h03;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  event_res;
		logic [31:0] timestamp;
		logic [7:0]  hundredths;
	} out_item_t;

	// one byte of crc-8, msb first, no reflection
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/sfc_cfg_regs.sv
// apb register file for the sync frame checker: holds the start marker
// depends on sfc_pkg
`default_nettype none

module sfc_cfg_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [7:0]  sof_marker
);

	logic [7:0] sof_marker_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & (paddr[2] == sfc_pkg::REG_SOF_MARKER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_marker_q <= sfc_pkg::SOF_RESET;
		end else if (wr_en) begin
			sof_marker_q <= pwdata[7:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			sfc_pkg::REG_SOF_MARKER: prdata = {24'd0, sof_marker_q};
			default:                 prdata = 32'd0;
		endcase
	end

	assign sof_marker = sof_marker_q;

endmodule

`default_nettype wire

### rtl/sfc_frame_core.sv
// frame state (position, crc, captured fields) and the end-of-frame decision
// depends on sfc_pkg
`default_nettype none

module sfc_frame_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire sfc_pkg::in_item_t item,
	input  wire logic [7:0]       sof_marker,
	output sfc_pkg::out_item_t    result
);

	logic [3:0]  pos_q;
	logic [7:0]  crc_q;
	logic        marker_good_q;
	logic [7:0]  cmd_q;
	logic [31:0] secs_q;
	logic [7:0]  hund_q;
	logic [7:0]  b;

	assign b = item.rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= 4'd0;
			crc_q         <= 8'd0;
			marker_good_q <= 1'b0;
			cmd_q         <= 8'd0;
			secs_q        <= 32'd0;
			hund_q        <= 8'd0;
		end else if (step) begin
			if (item.last_byte) begin
				pos_q         <= 4'd0;
				crc_q         <= 8'd0;
				marker_good_q <= 1'b0;
				cmd_q         <= 8'd0;
				secs_q        <= 32'd0;
				hund_q        <= 8'd0;
			end else begin
				case (pos_q) inside
					4'd0:                      marker_good_q <= (b == sof_marker);
					4'd1:                      cmd_q <= b;
					4'd2, 4'd3, 4'd4, 4'd5:    secs_q <= {secs_q[23:0], b};
					4'd6:                      hund_q <= b;
					default: ;
				endcase
				if (pos_q < sfc_pkg::POS_LAST) begin
					crc_q <= sfc_pkg::crc8_byte(crc_q, b);
				end
				if (pos_q < sfc_pkg::POS_SAT) begin
					pos_q <= pos_q + 4'd1;
				end
			end
		end
	end

	// checks in priority order: length, marker, crc
	always_comb begin
		result = '0;
		if (pos_q != sfc_pkg::POS_LAST) begin
			result.status = sfc_pkg::ST_LEN;
		end else if (!marker_good_q) begin
			result.status = sfc_pkg::ST_SOF;
		end else if (b != crc_q) begin
			result.status = sfc_pkg::ST_CRC;
		end else begin
			result.status     = sfc_pkg::ST_OK;
			result.timestamp  = secs_q;
			result.hundredths = hund_q;
			case (cmd_q) inside
				sfc_pkg::CMD_START:                         result.event_res = sfc_pkg::EV_START;
				sfc_pkg::CMD_HALT, sfc_pkg::CMD_HALT_REQ:   result.event_res = sfc_pkg::EV_STOP;
				sfc_pkg::CMD_QUERY:                         result.event_res = sfc_pkg::EV_POLL;
				default:                                    result.event_res = sfc_pkg::EV_NONE;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/sync_frame_checker.sv
// sync_frame_checker: the final byte of a frame passes the input register, then the result register, to out_valid
// throughput: one byte per clock; a result waiting on out_stall does not block the next byte
// only a final byte arriving while a result is still stalled holds off the input
// reset (arst_n low, asynchronous): frame state cleared, sof_marker back to 0xAA,
// input and result registers empty
`default_nettype none

module sync_frame_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// byte input channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire sfc_pkg::in_item_t   in_data,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sfc_pkg::out_item_t       out_data,
	// configuration port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready
);

`include "assert_macros.svh"

	// input register
	logic               valid_s1;
	sfc_pkg::in_item_t  item_s1;
	// result register
	logic               out_valid_q;
	sfc_pkg::out_item_t out_data_q;

	logic               adv_s1;   // item in s1 is consumed this cycle
	logic               emit;     // consumed item ends a frame
	logic [7:0]         sof_marker;
	sfc_pkg::out_item_t result;

	sfc_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.sof_marker (sof_marker)
	);

	// non-final bytes never need the result slot; a final byte needs it free or draining
	assign adv_s1   = valid_s1 & (~item_s1.last_byte | ~out_valid_q | ~out_stall);
	assign emit     = adv_s1 & item_s1.last_byte;
	assign in_stall = valid_s1 & ~adv_s1;

	sfc_frame_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv_s1),
		.item       (item_s1),
		.sof_marker (sof_marker),
		.result     (result)
	);

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a failed frame carries no event and no captured time
	`ASSERT_IMPLY(a_fail_no_payload, clk, arst_n,
		out_valid_q && (out_data_q.status != sfc_pkg::ST_OK),
		(out_data_q.event_res == sfc_pkg::EV_NONE) && (out_data_q.timestamp == 32'd0) &&
		(out_data_q.hundredths == 8'd0))

	// the input only stalls behind a final byte waiting for a stalled result
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n,
		in_stall, valid_s1 && item_s1.last_byte && out_valid_q && out_stall)

	// a held result is not overwritten by the next frame
	`ASSERT_NEXT(a_result_held, clk, arst_n,
		out_valid_q && out_stall, out_valid_q && (out_data_q == $past(out_data_q)))

	// a new result only follows a consumed final byte
	`ASSERT_NEXT(a_result_source, clk, arst_n,
		!emit && !(out_valid_q && out_stall), !out_valid_q)

endmodule

`default_nettype wire

### sim/sync_frame_checker_test.sv
// self-checking testbench for sync_frame_checker: framed bytes in, one result per frame out
// depends on sfc_pkg (item types, status, event, command and register codes) and the rtl top
`default_nettype none

module sync_frame_checker_test;
	timeunit 1ns;
	timeprecision 1ps;

	// register map: sof_marker is register 0, byte address 4*index
	localparam logic [2:0] SOF_MARKER_ADDR = {sfc_pkg::REG_SOF_MARKER, 2'b00};

	// a result leaves through the input and result registers after the final byte; settle before a write
	localparam int SETTLE_CYCLES   = 6;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int PHASE_ITEMS     = 240;

	localparam sfc_pkg::out_item_t LEN_RESULT = '{sfc_pkg::ST_LEN, sfc_pkg::EV_NONE, 32'h0, 8'h0};
	localparam sfc_pkg::out_item_t CRC_RESULT = '{sfc_pkg::ST_CRC, sfc_pkg::EV_NONE, 32'h0, 8'h0};
	localparam sfc_pkg::out_item_t NO_RESULT  = '0;

	// one row of the directed part; add_crc xors value with the running crc
	typedef struct packed {
		logic [7:0]         value;
		logic               last;
		logic               add_crc;
		logic               typed;
		sfc_pkg::out_item_t result;
	} dir_row_t;

	localparam int DIR_ROWS = 26;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// one-byte frame right after reset: too short
		'{8'hFF, 1'b1, 1'b0, 1'b1, LEN_RESULT},
		// good frame, start tick, all-zero time fields, correct crc
		'{sfc_pkg::SOF_RESET, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{sfc_pkg::CMD_START, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b1, 1'b1, 1'b0, NO_RESULT},
		// poll frame, all-ones time fields, every crc bit flipped
		'{sfc_pkg::SOF_RESET, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{sfc_pkg::CMD_QUERY, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b1, 1'b1, 1'b1, CRC_RESULT},
		// stop frame with good crc but one byte too many
		'{sfc_pkg::SOF_RESET, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{sfc_pkg::CMD_HALT, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h12, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h34, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h56, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h78, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h9A, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b1, 1'b0, NO_RESULT},
		'{8'h5A, 1'b1, 1'b0, 1'b1, LEN_RESULT}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	sfc_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_stall;
	sfc_pkg::out_item_t out_data;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	sync_frame_checker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// frame decoder mirror: marker register plus the per-frame captures
	logic [7:0]  marker_reg;
	logic [3:0]  frame_pos;
	logic [7:0]  frame_crc;
	logic        sof_ok;
	logic [7:0]  cmd_held;
	logic [31:0] secs_held;
	logic [7:0]  hund_held;
	logic        crc_ok;

	sfc_pkg::out_item_t pending_results [$];
	int                 fail_count;
	int                 items_sent;
	int                 src_gap_max;
	int                 snk_gap_max;
	logic               hold_off_req;
	int                 idle_cycles;

	// clock, 2 ns period
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// crc-8, poly 0x07, fed one data bit at a time, msb first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] acc;
		logic       fb;
		acc = crc;
		for (int i = 7; i >= 0; i--) begin
			fb  = acc[7] ^ data[i];
			acc = {acc[6:0], 1'b0} ^ (fb ? sfc_pkg::CRC_POLY : 8'h00);
		end
		return acc;
	endfunction

	task automatic clear_frame_state();
		frame_pos = '0;
		frame_crc = '0;
		sof_ok    = 1'b0;
		cmd_held  = '0;
		secs_held = '0;
		hund_held = '0;
		crc_ok    = 1'b0;
	endtask

	// advance the mirror by one accepted byte; a final byte yields one result
	task automatic decode_byte(input sfc_pkg::in_item_t item, output logic done,
			output sfc_pkg::out_item_t res);
		logic [3:0] pos;
		pos  = frame_pos;
		done = 1'b0;
		res  = '0;
		case (pos) inside
			4'd0: begin
				sof_ok = (item.rx_byte == marker_reg);
			end
			4'd1: begin
				cmd_held = item.rx_byte;
			end
			4'd2, 4'd3, 4'd4, 4'd5: begin
				secs_held = {secs_held[23:0], item.rx_byte};
			end
			4'd6: begin
				hund_held = item.rx_byte;
			end
			sfc_pkg::POS_LAST: begin
				crc_ok = (item.rx_byte == frame_crc);
			end
			default: ;
		endcase
		// crc covers positions 0..6 only; position saturates
		if (pos < sfc_pkg::POS_LAST) frame_crc = crc8_step(frame_crc, item.rx_byte);
		if (pos < sfc_pkg::POS_SAT) frame_pos = pos + 4'd1;
		if (item.last_byte) begin
			done = 1'b1;
			if (pos != sfc_pkg::POS_LAST) begin
				res.status = sfc_pkg::ST_LEN;
			end else if (!sof_ok) begin
				res.status = sfc_pkg::ST_SOF;
			end else if (!crc_ok) begin
				res.status = sfc_pkg::ST_CRC;
			end else begin
				res.status = sfc_pkg::ST_OK;
				case (cmd_held) inside
					sfc_pkg::CMD_START:    res.event_res = sfc_pkg::EV_START;
					sfc_pkg::CMD_HALT,
					sfc_pkg::CMD_HALT_REQ: res.event_res = sfc_pkg::EV_STOP;
					sfc_pkg::CMD_QUERY:    res.event_res = sfc_pkg::EV_POLL;
					default:               res.event_res = sfc_pkg::EV_NONE;
				endcase
				res.timestamp  = secs_held;
				res.hundredths = hund_held;
			end
			clear_frame_state();
		end
	endtask

	// offer one item after a random gap, hold it until taken, then predict;
	// called and returning at a falling edge
	task automatic send_byte(input sfc_pkg::in_item_t item, input logic typed,
			input sfc_pkg::out_item_t typed_res);
		int unsigned        gap;
		logic               done;
		sfc_pkg::out_item_t res;
		gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall);
		decode_byte(item, done, res);
		if (done) pending_results.push_back(typed ? typed_res : res);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic cfg_read(input logic [2:0] addr, output logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// read the marker back and compare with the mirror
	task automatic check_marker();
		logic [31:0] rd;
		cfg_read(SOF_MARKER_ADDR, rd);
		if (rd !== {24'h0, marker_reg}) begin
			$error("sof_marker readback: expected %0h, got %0h", marker_reg, rd);
			fail_count++;
		end
	endtask

	// stop offering, wait for every expected result, then let the pipeline settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// one random frame: mostly well formed with random content, some with
	// a wrong marker, a bad crc, or a short or long length
	task automatic send_frame();
		int unsigned       len;
		int unsigned       shape;
		logic [7:0]        b;
		sfc_pkg::in_item_t item;
		shape = $urandom_range(0, 99);
		len   = 8;
		if (shape < 8) begin
			len = $urandom_range(1, 7);
		end else if (shape < 14) begin
			len = $urandom_range(9, 12);
		end
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i == 0 && $urandom_range(0, 9) != 0) b = marker_reg;
			if (i == 1 && $urandom_range(0, 4) != 0) begin
				case ($urandom_range(0, 3))
					0: b = sfc_pkg::CMD_START;
					1: b = sfc_pkg::CMD_HALT;
					2: b = sfc_pkg::CMD_HALT_REQ;
					default: b = sfc_pkg::CMD_QUERY;
				endcase
			end
			// crc of bytes 0..6 is known once byte 6 has been taken
			if (i == 7 && $urandom_range(0, 9) != 0) b = frame_crc;
			item.rx_byte   = b;
			item.last_byte = (i == len - 1);
			send_byte(item, 1'b0, NO_RESULT);
		end
	endtask

	// a few random bytes with random end flags; can leave a frame open
	task automatic send_noise();
		sfc_pkg::in_item_t item;
		repeat ($urandom_range(1, 6)) begin
			item.rx_byte   = 8'($urandom);
			item.last_byte = ($urandom_range(0, 3) == 0);
			send_byte(item, 1'b0, NO_RESULT);
		end
	endtask

	// random stimulus for one phase; always closes the open frame at the end
	task automatic run_phase();
		int                start;
		sfc_pkg::in_item_t item;
		start = items_sent;
		while (items_sent - start < PHASE_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				send_noise();
			end else begin
				send_frame();
			end
		end
		if (frame_pos != 0) begin
			item.rx_byte   = 8'($urandom);
			item.last_byte = 1'b1;
			send_byte(item, 1'b0, NO_RESULT);
		end
	endtask

	// result checker: every taken result against the oldest expectation
	always @(posedge clk) begin
		sfc_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d event %0d", out_data.status,
					out_data.event_res);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_data.status);
					fail_count++;
				end
				if (out_data.event_res !== want.event_res) begin
					$error("event_res: expected %0d, got %0d", want.event_res,
						out_data.event_res);
					fail_count++;
				end
				if (out_data.timestamp !== want.timestamp) begin
					$error("timestamp: expected %0h, got %0h", want.timestamp,
						out_data.timestamp);
					fail_count++;
				end
				if (out_data.hundredths !== want.hundredths) begin
					$error("hundredths: expected %0h, got %0h", want.hundredths,
						out_data.hundredths);
					fail_count++;
				end
			end
		end
	end

	// result side: random stall before each result, plus one long hold-off on request
	initial begin : result_sink
		int unsigned gap;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				// long hold-off: lets the block fill up and stall its input
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			gap = (snk_gap_max == 0) ? 0 : $urandom_range(0, snk_gap_max);
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	// watchdog: too long without any item or register access moving
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		dir_row_t          row;
		sfc_pkg::in_item_t item;
		logic [7:0]        next_marker;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		fail_count   = 0;
		items_sent   = 0;
		idle_cycles  = 0;
		hold_off_req = 1'b0;
		src_gap_max  = 10;
		snk_gap_max  = 10;
		marker_reg   = sfc_pkg::SOF_RESET;
		clear_frame_state();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// marker comes out of reset at its default
		check_marker();

		// directed frames
		for (int r = 0; r < DIR_ROWS; r++) begin
			row            = DIRECTED[r];
			item.rx_byte   = row.add_crc ? (frame_crc ^ row.value) : row.value;
			item.last_byte = row.last;
			send_byte(item, row.typed, row.result);
		end

		// phases with different markers and idling; sender pauses for the drain
		// before each marker write
		for (int p = 0; p < 5; p++) begin
			if (p != 0) begin
				drain_results();
				case (p)
					1: next_marker = 8'h00;
					2: next_marker = 8'hFF;
					3: next_marker = 8'($urandom);
					default: next_marker = sfc_pkg::SOF_RESET;
				endcase
				cfg_write(SOF_MARKER_ADDR, {24'h0, next_marker});
				marker_reg = next_marker;
				check_marker();
			end
			case (p)
				0: begin
					src_gap_max = 10;
					snk_gap_max = 10;
				end
				1: begin
					// back-to-back bytes into a receiver that holds off for a while
					src_gap_max  = 0;
					snk_gap_max  = 10;
					hold_off_req = 1'b1;
				end
				2: begin
					src_gap_max = 10;
					snk_gap_max = 0;
				end
				3: begin
					// no idling on either side
					src_gap_max = 0;
					snk_gap_max = 0;
				end
				default: begin
					src_gap_max = 10;
					snk_gap_max = 10;
				end
			endcase
			run_phase();
		end

		drain_results();
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/sfc_pkg.sv
rtl/sfc_cfg_regs.sv
rtl/sfc_frame_core.sv
rtl/sync_frame_checker.sv
sim/sync_frame_checker_test.sv
